/* design/tcg_pkg.sv */
package tcg_pkg;

	localparam int CELL_WIDTH = 8;
	localparam int GLYPH_ROWS = 8;
	localparam int CODE_W     = 8;
	localparam int GROW_W     = 3;
	localparam int GADDR_W    = CODE_W + GROW_W;
	localparam int POS_W      = 14;   // holds any coordinate up to the largest screen plus a cell
	localparam int PITCH_W    = 13;
	localparam int CFG_DIM_W  = 13;
	localparam int IDX_W      = 24;
	localparam int COLOR_W    = 32;
	localparam int KCNT_W     = 6;    // 64 pixels per cell

	localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;

	typedef enum logic {
		OP_PUT  = 1'b0,
		OP_LOAD = 1'b1
	} op_t;

	typedef enum logic {
		JOB_CHAR  = 1'b0,
		JOB_CLEAR = 1'b1
	} job_kind_t;

	typedef enum logic [2:0] {
		REG_DISP_WIDTH     = 3'd0,
		REG_DISP_HEIGHT    = 3'd1,
		REG_SCANLINE_PITCH = 3'd2,
		REG_FORE_COLOR     = 3'd3,
		REG_BACK_COLOR     = 3'd4
	} cfg_reg_t;

	// work handed from the cursor stage to the pixel expander
	typedef struct packed {
		job_kind_t          kind;
		logic [CODE_W-1:0]  code;
		logic [POS_W-1:0]   x0;
		logic [POS_W-1:0]   y0;
		logic [IDX_W-1:0]   base;
		logic               clr;
	} job_t;

	typedef struct packed {
		logic               we;
		logic [GADDR_W-1:0] addr;
		logic [7:0]         data;
	} glyph_wr_t;

	typedef struct packed {
		logic               re;
		logic [GADDR_W-1:0] addr;
	} glyph_rd_t;

endpackage

/* design/tcg_glyph_mem.sv */
module tcg_glyph_mem (
	input  logic                clk,
	input  tcg_pkg::glyph_wr_t  wr,
	input  tcg_pkg::glyph_rd_t  rd,
	output logic [7:0]          rdata
);
	import tcg_pkg::*;

	logic [7:0] mem [2**GADDR_W];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.re) begin
			rdata <= mem[rd.addr];
		end
	end

endmodule

/* design/tcg_cursor.sv */
module tcg_cursor #(
	parameter int LINE_ADVANCE = 12,
	parameter int MAX_DIM      = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [23:0]                    s_axis_tdata,  // char_code, glyph_row, row_bits, zero pad
	input  logic                           s_axis_tuser,  // opcode
	input  logic [tcg_pkg::POS_W-1:0]      disp_width,
	input  logic [tcg_pkg::POS_W-1:0]      disp_height,
	input  logic [tcg_pkg::PITCH_W-1:0]    scanline_pitch,
	input  logic                           job_ready,
	output logic                           job_valid,
	output tcg_pkg::job_t                  job,
	output tcg_pkg::glyph_wr_t             glyph_wr
);
	import tcg_pkg::*;

	localparam int CW = $clog2(MAX_DIM);
	localparam int SW = POS_W + 1;
	localparam int PW = POS_W + PITCH_W;
	localparam logic [SW-1:0] LA   = SW'(LINE_ADVANCE);
	localparam logic [SW-1:0] CELL = SW'(CELL_WIDTH);

	logic              s1_valid;
	op_t               op_s1;
	logic [CODE_W-1:0] code_s1;
	logic [GROW_W-1:0] grow_s1;
	logic [7:0]        bits_s1;
	logic [CW-1:0]     column_q;
	logic [CW-1:0]     line_q;

	logic          retire;
	logic          is_nl;
	logic [SW-1:0] col_e, line_e, w_e, h_e;
	logic [SW-1:0] nl_line, col_a, col_b, line_b;
	logic          nl_clr, wrap, ch_clr;
	logic [SW-1:0] ch_col, ch_line;
	logic [PW-1:0] prod;

	always_comb begin
		retire  = s1_valid && job_ready;
		is_nl   = (code_s1 == NEWLINE_CODE);
		col_e   = SW'(column_q);
		line_e  = SW'(line_q);
		w_e     = SW'(disp_width);
		h_e     = SW'(disp_height);

		nl_line = line_e + LA;
		nl_clr  = (nl_line + LA) > h_e;

		col_a   = col_e + CELL;
		wrap    = (col_a + CELL) > w_e;
		col_b   = wrap ? '0 : col_a;
		line_b  = wrap ? (line_e + LA) : line_e;
		ch_clr  = (line_b + LA) > h_e;
		ch_col  = ch_clr ? '0 : col_b;
		ch_line = ch_clr ? '0 : line_b;

		s_axis_tready = !s1_valid || retire;

		job_valid = s1_valid && (op_s1 == OP_PUT) && (!is_nl || nl_clr);
		job.kind  = is_nl ? JOB_CLEAR : JOB_CHAR;
		job.code  = code_s1;
		job.x0    = POS_W'(column_q);
		job.y0    = POS_W'(line_q);
		prod      = PW'(job.y0) * PW'(scanline_pitch);
		job.base  = IDX_W'(prod + PW'(job.x0));
		job.clr   = is_nl ? 1'b1 : ch_clr;

		glyph_wr.we   = retire && (op_s1 == OP_LOAD);
		glyph_wr.addr = {code_s1, grow_s1};
		glyph_wr.data = bits_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			column_q <= '0;
			line_q   <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				s1_valid <= 1'b1;
			end else if (retire) begin
				s1_valid <= 1'b0;
			end
			if (retire && (op_s1 == OP_PUT)) begin
				if (is_nl) begin
					column_q <= '0;
					line_q   <= nl_clr ? '0 : CW'(nl_line);
				end else begin
					column_q <= CW'(ch_col);
					line_q   <= CW'(ch_line);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_s1   <= op_t'(s_axis_tuser);
			code_s1 <= s_axis_tdata[7:0];
			grow_s1 <= s_axis_tdata[10:8];
			bits_s1 <= s_axis_tdata[18:11];
		end
	end

endmodule

/* design/tcg_expander.sv */
module tcg_expander (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           job_valid,
	input  tcg_pkg::job_t                  job,
	output logic                           job_ready,
	input  logic [tcg_pkg::POS_W-1:0]      disp_width,
	input  logic [tcg_pkg::POS_W-1:0]      disp_height,
	input  logic [tcg_pkg::PITCH_W-1:0]    scanline_pitch,
	input  logic [tcg_pkg::COLOR_W-1:0]    fore_color,
	input  logic [tcg_pkg::COLOR_W-1:0]    back_color,
	output tcg_pkg::glyph_rd_t             glyph_rd,
	input  logic [7:0]                     glyph_data,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [63:0]                    m_axis_tdata,  // pixel_index, pixel_color, zero pad
	output logic [1:0]                     m_axis_tuser,  // pixel_valid, clear_screen
	output logic                           m_axis_tlast
);
	import tcg_pkg::*;

	// generator: walks the 64 pixels of the current cell, or a single step for a clear job
	logic              gen_busy_q;
	job_t              gen_job_q;
	logic [KCNT_W-1:0] k_q;
	logic [IDX_W-1:0]  rowbase_q;

	// glyph row arrives from the store alongside this stage
	logic              s2_valid;
	logic [POS_W-1:0]  px_s2, py_s2;
	logic [IDX_W-1:0]  idx_s2;
	logic [2:0]        j_s2;
	logic              last_s2, clr_s2, mark_s2;

	logic               out_valid_q, out_pv_q, out_clr_q, out_last_q;
	logic [IDX_W-1:0]   out_idx_q;
	logic [COLOR_W-1:0] out_color_q;

	logic out_free, s2_free, gen_adv, gen_last, job_take, clip;

	always_comb begin
		out_free = !out_valid_q || m_axis_tready;
		s2_free  = !s2_valid || out_free;
		gen_adv  = gen_busy_q && s2_free;
		gen_last = (gen_job_q.kind == JOB_CLEAR) || (k_q == KCNT_W'(GLYPH_ROWS * CELL_WIDTH - 1));
		// next job may start as the last pixel of this one is issued
		job_ready = !gen_busy_q || (gen_adv && gen_last);
		job_take  = job_valid && job_ready;

		glyph_rd.re   = gen_adv;
		glyph_rd.addr = {gen_job_q.code, k_q[5:3]};

		clip = (px_s2 >= disp_width) || (py_s2 >= disp_height);

		m_axis_tvalid = out_valid_q;
		m_axis_tdata  = {8'h00, out_color_q, out_idx_q};
		m_axis_tuser  = {out_clr_q, out_pv_q};
		m_axis_tlast  = out_last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_busy_q  <= 1'b0;
			k_q         <= '0;
			s2_valid    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (job_take) begin
				gen_busy_q <= 1'b1;
				k_q        <= '0;
			end else if (gen_adv) begin
				if (gen_last) begin
					gen_busy_q <= 1'b0;
					k_q        <= '0;
				end else begin
					k_q <= k_q + 1'b1;
				end
			end

			if (gen_adv) begin
				s2_valid <= 1'b1;
			end else if (out_free) begin
				s2_valid <= 1'b0;
			end

			if (s2_valid && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_take) begin
			gen_job_q <= job;
			rowbase_q <= job.base;
		end else if (gen_adv && !gen_last && (k_q[2:0] == 3'd7)) begin
			rowbase_q <= rowbase_q + IDX_W'(scanline_pitch);
		end

		if (gen_adv) begin
			px_s2   <= gen_job_q.x0 + POS_W'(k_q[2:0]);
			py_s2   <= gen_job_q.y0 + POS_W'(k_q[5:3]);
			idx_s2  <= rowbase_q + IDX_W'(k_q[2:0]);
			j_s2    <= k_q[2:0];
			last_s2 <= gen_last;
			clr_s2  <= gen_last && gen_job_q.clr;
			mark_s2 <= (gen_job_q.kind == JOB_CLEAR);
		end

		if (s2_valid && out_free) begin
			out_clr_q  <= clr_s2;
			out_last_q <= last_s2;
			if (mark_s2 || clip) begin
				out_pv_q    <= 1'b0;
				out_idx_q   <= '0;
				out_color_q <= '0;
			end else begin
				out_pv_q    <= 1'b1;
				out_idx_q   <= idx_s2;
				out_color_q <= glyph_data[j_s2] ? fore_color : back_color;
			end
		end
	end

	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_clr_q |-> out_last_q)
		else $error("clear request on an item that is not last");

	a_marker_single: assert property (@(posedge clk) disable iff (!arst_n)
		gen_busy_q && (gen_job_q.kind == JOB_CLEAR) |-> k_q == '0)
		else $error("screen clear job stepped past its only result");

	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		s2_valid && mark_s2 |-> last_s2 && clr_s2)
		else $error("screen clear result without last and clear flags");

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		!gen_busy_q |-> k_q == '0)
		else $error("pixel counter left running while idle");

endmodule

/* design/text_cell_glyph_renderer_core.sv */
// Text console character generator with an 8x8 glyph store (2048 x 8 bits).
// A glyph-row load (opcode 1) writes one row and gives no result. A character
// (opcode 0) gives 64 pixel-write items, row by row, one per cycle while
// m_axis_tready is high, the last carrying tlast and, when the cursor ran off
// the bottom, clear_screen. A newline gives no item, or a single clear item
// when it runs off the bottom. A character occupies the pixel expander for
// all 64 of its pixels; loads and newlines retire only once the expander has
// issued its last pixel. Items pass the cursor stage, generator, glyph-read
// stage and output register. The glyph store has no reset and no clearing
// pass: drawing a row that was never loaded gives undefined colours.
// Configuration is to be written while idle; the block does not enforce it.
module text_cell_glyph_renderer_core #(
	parameter int LINE_ADVANCE = 12,
	parameter int MAX_DIM      = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // char_code[7:0], glyph_row[10:8], row_bits[18:11]
	input  logic        s_axis_tuser,   // opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // pixel_index[23:0], pixel_color[55:24]
	output logic [1:0]  m_axis_tuser,   // pixel_valid[0], clear_screen[1]
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import tcg_pkg::*;

	localparam int DW        = $clog2(MAX_DIM + 1);
	localparam int WIDTH_RST = (640 > MAX_DIM) ? MAX_DIM : 640;
	localparam int HEIGHT_RST = (480 > MAX_DIM) ? MAX_DIM : 480;
	localparam logic [POS_W-1:0] MAX_DIM_P = POS_W'(MAX_DIM);

	logic [DW-1:0]      disp_width_q, disp_height_q;
	logic [PITCH_W-1:0] scanline_pitch_q;
	logic [COLOR_W-1:0] fore_color_q, back_color_q;

	logic [POS_W-1:0] cfg_dim, cfg_raw;
	logic [POS_W-1:0] width_e, height_e;

	logic      job_valid, job_ready;
	job_t      job;
	glyph_wr_t glyph_wr;
	glyph_rd_t glyph_rd;
	logic [7:0] glyph_data;

	always_comb begin
		cfg_raw  = POS_W'(cfg_data[CFG_DIM_W-1:0]);
		cfg_dim  = (cfg_raw > MAX_DIM_P) ? MAX_DIM_P : cfg_raw;
		width_e  = POS_W'(disp_width_q);
		height_e = POS_W'(disp_height_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disp_width_q     <= DW'(WIDTH_RST);
			disp_height_q    <= DW'(HEIGHT_RST);
			scanline_pitch_q <= PITCH_W'(640);
			fore_color_q     <= '1;
			back_color_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_DISP_WIDTH:     disp_width_q     <= DW'(cfg_dim);
				REG_DISP_HEIGHT:    disp_height_q    <= DW'(cfg_dim);
				REG_SCANLINE_PITCH: scanline_pitch_q <= cfg_data[PITCH_W-1:0];
				REG_FORE_COLOR:     fore_color_q     <= cfg_data;
				REG_BACK_COLOR:     back_color_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	tcg_cursor #(
		.LINE_ADVANCE (LINE_ADVANCE),
		.MAX_DIM      (MAX_DIM)
	) u_cursor (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tuser   (s_axis_tuser),
		.disp_width     (width_e),
		.disp_height    (height_e),
		.scanline_pitch (scanline_pitch_q),
		.job_ready      (job_ready),
		.job_valid      (job_valid),
		.job            (job),
		.glyph_wr       (glyph_wr)
	);

	tcg_glyph_mem u_glyph_mem (
		.clk   (clk),
		.wr    (glyph_wr),
		.rd    (glyph_rd),
		.rdata (glyph_data)
	);

	tcg_expander u_expander (
		.clk            (clk),
		.arst_n         (arst_n),
		.job_valid      (job_valid),
		.job            (job),
		.job_ready      (job_ready),
		.disp_width     (width_e),
		.disp_height    (height_e),
		.scanline_pitch (scanline_pitch_q),
		.fore_color     (fore_color_q),
		.back_color     (back_color_q),
		.glyph_rd       (glyph_rd),
		.glyph_data     (glyph_data),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tuser   (m_axis_tuser),
		.m_axis_tlast   (m_axis_tlast)
	);

endmodule
